>>> rtl/ffsa_pkg.sv
package ffsa_pkg;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_FORMAT = 2'd2;

   // status codes carried in rsp_tuser
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ZERO_SIZE  = 2'd1;
   localparam logic [1:0] ST_OUT_OF_MEM = 2'd2;

   // register index, taken from paddr bit 3
   localparam logic REG_BASE_ADDRESS  = 1'b0;
   localparam logic REG_INITIAL_PAGES = 1'b1;

   localparam int GRAN_BYTES = 16;
   localparam int GRAN_SHIFT = 4;
   localparam int PAGE_BYTES = 4096;
   localparam int ADDR_W     = 48;
   localparam int SIZE_W     = 17;
   localparam int PAGES_W    = 5;

   typedef enum logic [4:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK_CHK,
      S_SPLIT_S,
      S_GROW,
      S_REL_CHK,
      S_REL_RD,
      S_REL_NX,
      S_REL_S,
      S_MRG_RD,
      S_MRG_A,
      S_MRG_B,
      S_FIX_RD,
      S_FIX_WR,
      S_RET,
      S_RESP
   } state_type;

   // where a merge pass continues when it is done
   typedef enum logic [1:0] {
      RET_WALK,
      RET_BACK,
      RET_DONE
   } ret_type;

endpackage

>>> rtl/first_fit_segment_allocator.sv
// first-fit segment allocator: headers live in one single-port-read header ram
// allocate: reads and checks each segment walked, then marks or splits the fit; growth adds a merge
// free: walks the segments up to the target, then up to two merges
// format, zero size and unknown ops answer without a walk; one item in flight at a time
// a new word is taken while the previous result still waits in the output register
// synchronous reset clears control state; header ram content is undefined until format
module first_fit_segment_allocator #(
   parameter int ARENA_BYTES  = 65536,
   parameter int HEADER_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // request_size[16:0], free_address[64:17], zero fill
   input  logic [1:0]  req_tuser,  // op[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // block_address[47:0]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW        = $clog2(ARENA_BYTES);
   localparam int OW        = (AW + 2 > 18) ? AW + 2 : 18;  // offset math width
   localparam int SW        = AW - ffsa_pkg::GRAN_SHIFT;      // slot index width
   localparam int LW        = AW;                             // stored length width
   localparam int EW        = AW + 1;                         // arena end width
   localparam int SEG_COUNT = ARENA_BYTES / ffsa_pkg::GRAN_BYTES;
   localparam int MW        = 1 + LW + SW;
   localparam int MAX_PAGES = ARENA_BYTES / ffsa_pkg::PAGE_BYTES;
   localparam int RESET_END = (16 * ffsa_pkg::PAGE_BYTES > ARENA_BYTES) ?
                              ARENA_BYTES : 16 * ffsa_pkg::PAGE_BYTES;

   localparam logic [OW-1:0] HDR_OW   = OW'(HEADER_BYTES);
   localparam logic [OW-1:0] ARENA_OW = OW'(ARENA_BYTES);
   localparam logic [OW-1:0] SPLIT_MIN = OW'(HEADER_BYTES + ffsa_pkg::GRAN_BYTES);
   localparam logic [OW-1:0] GRAN_M1  = OW'(ffsa_pkg::GRAN_BYTES - 1);
   localparam logic [OW-1:0] PAGE_M1  = OW'(ffsa_pkg::PAGE_BYTES - 1);

   // state and registers
   ffsa_pkg::state_type state_ff, state_in;
   ffsa_pkg::ret_type   ret_ff, ret_in;

   logic [OW-1:0] off_ff, off_in;
   logic [OW-1:0] size_ff, size_in;
   logic [OW-1:0] target_ff, target_in;
   logic [EW-1:0] arena_end_ff, arena_end_in;
   logic [SW-1:0] last_ff, last_in;
   logic [47:0]   base_ff, base_in;
   logic [4:0]    pages_ff, pages_in;
   logic [47:0]   rel_ff, rel_in;
   logic [SW-1:0] cur_slot_ff, cur_slot_in;
   logic [SW-1:0] cur_prev_ff, cur_prev_in;
   logic [SW-1:0] split_ns_ff, split_ns_in;
   logic [SW-1:0] m_slot_ff, m_slot_in;
   logic [LW-1:0] m_len_ff, m_len_in;
   logic [SW-1:0] m_prev_ff, m_prev_in;
   logic [SW-1:0] n_slot_ff, n_slot_in;
   logic [SW-1:0] fix_slot_ff, fix_slot_in;
   logic [SW-1:0] fix_prev_ff, fix_prev_in;
   logic          fix_go_ff, fix_go_in;
   logic          fix_merge_ff, fix_merge_in;
   logic [47:0]   res_addr_ff, res_addr_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   rsp_addr_ff, rsp_addr_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   // header ram port
   logic          mem_we, mem_re;
   logic [SW-1:0] mem_waddr, mem_raddr;
   logic          wr_free;
   logic [LW-1:0] wr_len;
   logic [SW-1:0] wr_prev;
   logic [MW-1:0] mem_rdata;
   logic          rd_free;
   logic [LW-1:0] rd_len;
   logic [SW-1:0] rd_prev;

   assign rd_free = mem_rdata[MW-1];
   assign rd_len  = mem_rdata[SW +: LW];
   assign rd_prev = mem_rdata[SW-1:0];

   ffsa_hdr_ram #(
      .DEPTH  (SEG_COUNT),
      .ADDR_W (SW),
      .DATA_W (MW)
   ) u_hdr_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata ({wr_free, wr_len, wr_prev}),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // request fields
   logic                      req_fire;
   logic [1:0]                in_op;
   logic [ffsa_pkg::SIZE_W-1:0] in_size;
   logic [47:0]               in_addr;

   assign req_tready = (state_ff == ffsa_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_op      = req_tuser;
   assign in_size    = req_tdata[16:0];
   assign in_addr    = req_tdata[64:17];

   // shared datapath terms
   logic [OW-1:0] size_calc;
   logic [OW-1:0] arena_ow;
   logic [SW-1:0] off_slot;
   logic [OW-1:0] rd_len_ow;
   logic          walk_fit;
   logic          walk_split;
   logic [OW-1:0] walk_next;
   logic [OW-1:0] split_off;
   logic [OW-1:0] grow;
   logic          grow_fail;
   logic [SW-1:0] grow_ns;
   logic [OW-1:0] slot_end;
   logic [OW-1:0] m_end;
   logic          m_end_in;
   logic [OW-1:0] merged_len;
   logic [OW-1:0] merged_end;
   logic          rel_bad;
   logic          rel_walk;
   logic          rel_miss;
   logic [4:0]    pages_eff;
   logic [EW-1:0] fmt_end;

   assign size_calc  = (OW'(in_size) + GRAN_M1) & ~GRAN_M1;
   assign arena_ow   = OW'(arena_end_ff);
   assign off_slot   = off_ff[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
   assign rd_len_ow  = OW'(rd_len);
   assign walk_fit   = rd_free && (rd_len_ow >= size_ff);
   assign walk_split = (rd_len_ow - size_ff) >= SPLIT_MIN;
   assign walk_next  = off_ff + HDR_OW + rd_len_ow;
   assign split_off  = off_ff + HDR_OW + size_ff;
   assign grow       = (size_ff + PAGE_M1) & ~PAGE_M1;
   assign grow_fail  = (arena_ow > ARENA_OW) || (grow > ARENA_OW - arena_ow);
   assign grow_ns    = arena_end_ff[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
   // end of the segment at the current walk slot (free path walks by slot)
   assign slot_end   = OW'({off_slot, {ffsa_pkg::GRAN_SHIFT{1'b0}}}) + HDR_OW + rd_len_ow;
   assign m_end      = OW'({m_slot_ff, {ffsa_pkg::GRAN_SHIFT{1'b0}}}) + HDR_OW + rd_len_ow;
   assign m_end_in   = m_end < arena_ow;
   assign merged_len = OW'(m_len_ff) + rd_len_ow + HDR_OW;
   assign merged_end = OW'({m_slot_ff, {ffsa_pkg::GRAN_SHIFT{1'b0}}}) + HDR_OW + merged_len;
   assign rel_bad    = (rel_ff < 48'(HEADER_BYTES)) ||
                       ((rel_ff - 48'(HEADER_BYTES)) >= 48'(arena_end_ff));
   assign rel_walk   = (off_ff < arena_ow) && (off_ff < target_ff);
   assign rel_miss   = (off_ff != target_ff) || (off_ff >= arena_ow);

   // initial page count, out-of-range counts clamped
   always_comb begin
      if (pages_ff == 5'd0) begin
         pages_eff = 5'd1;
      end else if (32'(pages_ff) > MAX_PAGES) begin
         pages_eff = 5'(MAX_PAGES);
      end else begin
         pages_eff = pages_ff;
      end
   end
   assign fmt_end = EW'(32'(pages_eff) * ffsa_pkg::PAGE_BYTES);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffsa_pkg::S_IDLE: begin
            if (req_fire) begin
               if (in_op == ffsa_pkg::OP_ALLOC && size_calc != '0) begin
                  state_in = ffsa_pkg::S_WALK_RD;
               end else if (in_op == ffsa_pkg::OP_FREE) begin
                  state_in = ffsa_pkg::S_REL_CHK;
               end else begin
                  state_in = ffsa_pkg::S_RESP;
               end
            end
         end
         ffsa_pkg::S_WALK_RD: begin
            state_in = (off_ff >= arena_ow) ? ffsa_pkg::S_GROW : ffsa_pkg::S_WALK_CHK;
         end
         ffsa_pkg::S_WALK_CHK: begin
            if (!walk_fit) begin
               state_in = ffsa_pkg::S_WALK_RD;
            end else if (walk_split) begin
               state_in = ffsa_pkg::S_SPLIT_S;
            end else begin
               state_in = ffsa_pkg::S_RESP;
            end
         end
         ffsa_pkg::S_SPLIT_S: begin
            state_in = fix_go_ff ? ffsa_pkg::S_FIX_RD : ffsa_pkg::S_RESP;
         end
         ffsa_pkg::S_GROW: begin
            if (grow_fail) begin
               state_in = ffsa_pkg::S_RESP;
            end else if (grow_ns != '0) begin
               state_in = ffsa_pkg::S_MRG_RD;
            end else begin
               state_in = ffsa_pkg::S_WALK_RD;
            end
         end
         ffsa_pkg::S_REL_CHK: begin
            state_in = rel_bad ? ffsa_pkg::S_RESP : ffsa_pkg::S_REL_RD;
         end
         ffsa_pkg::S_REL_RD: begin
            if (rel_walk) begin
               state_in = ffsa_pkg::S_REL_NX;
            end else if (rel_miss) begin
               state_in = ffsa_pkg::S_RESP;
            end else begin
               state_in = ffsa_pkg::S_REL_S;
            end
         end
         ffsa_pkg::S_REL_NX: state_in = ffsa_pkg::S_REL_RD;
         ffsa_pkg::S_REL_S: begin
            state_in = rd_free ? ffsa_pkg::S_RESP : ffsa_pkg::S_MRG_RD;
         end
         ffsa_pkg::S_MRG_RD: state_in = ffsa_pkg::S_MRG_A;
         ffsa_pkg::S_MRG_A: begin
            state_in = (rd_free && m_end_in) ? ffsa_pkg::S_MRG_B : ffsa_pkg::S_RET;
         end
         ffsa_pkg::S_MRG_B: begin
            if (rd_free && n_slot_ff != m_slot_ff && merged_end < arena_ow) begin
               state_in = ffsa_pkg::S_FIX_RD;
            end else begin
               state_in = ffsa_pkg::S_RET;
            end
         end
         ffsa_pkg::S_FIX_RD: state_in = ffsa_pkg::S_FIX_WR;
         ffsa_pkg::S_FIX_WR: begin
            state_in = fix_merge_ff ? ffsa_pkg::S_RET : ffsa_pkg::S_RESP;
         end
         ffsa_pkg::S_RET: begin
            unique case (ret_ff)
               ffsa_pkg::RET_WALK: state_in = ffsa_pkg::S_WALK_RD;
               ffsa_pkg::RET_BACK: begin
                  state_in = (cur_slot_ff != '0) ? ffsa_pkg::S_MRG_RD : ffsa_pkg::S_RESP;
               end
               default: state_in = ffsa_pkg::S_RESP;
            endcase
         end
         ffsa_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ffsa_pkg::S_IDLE;
            end
         end
         default: state_in = ffsa_pkg::S_IDLE;
      endcase
   end

   // datapath, ram and output controls
   always_comb begin
      ret_in        = ret_ff;
      off_in        = off_ff;
      size_in       = size_ff;
      target_in     = target_ff;
      arena_end_in  = arena_end_ff;
      last_in       = last_ff;
      base_in       = base_ff;
      pages_in      = pages_ff;
      rel_in        = rel_ff;
      cur_slot_in   = cur_slot_ff;
      cur_prev_in   = cur_prev_ff;
      split_ns_in   = split_ns_ff;
      m_slot_in     = m_slot_ff;
      m_len_in      = m_len_ff;
      m_prev_in     = m_prev_ff;
      n_slot_in     = n_slot_ff;
      fix_slot_in   = fix_slot_ff;
      fix_prev_in   = fix_prev_ff;
      fix_go_in     = fix_go_ff;
      fix_merge_in  = fix_merge_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = '0;
      mem_raddr     = off_slot;
      wr_free       = 1'b0;
      wr_len        = '0;
      wr_prev       = '0;

      // register writes, to be done only while idle; the block itself does not enforce it
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[3])
            ffsa_pkg::REG_BASE_ADDRESS:  base_in  = csr_pwdata[47:0];
            ffsa_pkg::REG_INITIAL_PAGES: pages_in = csr_pwdata[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ffsa_pkg::S_IDLE: begin
            if (req_fire) begin
               res_addr_in   = '0;
               res_status_in = ffsa_pkg::ST_OK;
               size_in       = size_calc;
               off_in        = '0;
               rel_in        = in_addr - base_ff;
               if (in_op == ffsa_pkg::OP_ALLOC && size_calc == '0) begin
                  res_status_in = ffsa_pkg::ST_ZERO_SIZE;
               end
               if (in_op == ffsa_pkg::OP_FORMAT) begin
                  // one free segment spanning the arena
                  arena_end_in = fmt_end;
                  last_in      = '0;
                  mem_we       = 1'b1;
                  mem_waddr    = '0;
                  wr_free      = 1'b1;
                  wr_len       = LW'(fmt_end - EW'(HEADER_BYTES));
                  wr_prev      = '0;
               end
            end
         end
         ffsa_pkg::S_WALK_RD: begin
            mem_re    = (off_ff < arena_ow);
            mem_raddr = off_slot;
         end
         ffsa_pkg::S_WALK_CHK: begin
            if (!walk_fit) begin
               off_in = walk_next;
            end else begin
               res_addr_in = base_ff + 48'(off_ff) + 48'(HEADER_BYTES);
               cur_slot_in = off_slot;
               cur_prev_in = rd_prev;
               mem_we      = 1'b1;
               if (walk_split) begin
                  // carve the remainder into a new free segment
                  split_ns_in = split_off[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
                  mem_waddr   = split_off[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
                  wr_free     = 1'b1;
                  wr_len      = LW'(rd_len_ow - size_ff - HDR_OW);
                  wr_prev     = off_slot;
                  fix_slot_in = walk_next[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
                  fix_prev_in = split_off[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
                  fix_go_in   = walk_next < arena_ow;
                  fix_merge_in = 1'b0;
               end else begin
                  mem_waddr = off_slot;
                  wr_free   = 1'b0;
                  wr_len    = rd_len;
                  wr_prev   = rd_prev;
               end
            end
         end
         ffsa_pkg::S_SPLIT_S: begin
            mem_we    = 1'b1;
            mem_waddr = cur_slot_ff;
            wr_free   = 1'b0;
            wr_len    = LW'(size_ff);
            wr_prev   = cur_prev_ff;
            if (last_ff == cur_slot_ff) begin
               last_in = split_ns_ff;
            end
         end
         ffsa_pkg::S_GROW: begin
            if (grow_fail) begin
               res_status_in = ffsa_pkg::ST_OUT_OF_MEM;
               res_addr_in   = '0;
            end else begin
               // append pages as a free segment, then merge it backward
               mem_we       = 1'b1;
               mem_waddr    = grow_ns;
               wr_free      = 1'b1;
               wr_len       = LW'(grow - HDR_OW);
               wr_prev      = last_ff;
               arena_end_in = arena_end_ff + EW'(grow);
               last_in      = grow_ns;
               m_slot_in    = last_ff;
               ret_in       = ffsa_pkg::RET_WALK;
               off_in       = '0;
            end
         end
         ffsa_pkg::S_REL_CHK: begin
            target_in = OW'(rel_ff - 48'(HEADER_BYTES));
            off_in    = '0;
         end
         ffsa_pkg::S_REL_RD: begin
            if (rel_walk) begin
               mem_re    = 1'b1;
               mem_raddr = off_slot;
            end else if (!rel_miss) begin
               mem_re      = 1'b1;
               mem_raddr   = off_slot;
               cur_slot_in = off_slot;
            end
         end
         ffsa_pkg::S_REL_NX: begin
            off_in = slot_end;
         end
         ffsa_pkg::S_REL_S: begin
            if (!rd_free) begin
               mem_we      = 1'b1;
               mem_waddr   = cur_slot_ff;
               wr_free     = 1'b1;
               wr_len      = rd_len;
               wr_prev     = rd_prev;
               cur_prev_in = rd_prev;
               m_slot_in   = cur_slot_ff;
               ret_in      = ffsa_pkg::RET_BACK;
            end
         end
         ffsa_pkg::S_MRG_RD: begin
            mem_re    = 1'b1;
            mem_raddr = m_slot_ff;
         end
         ffsa_pkg::S_MRG_A: begin
            m_len_in  = rd_len;
            m_prev_in = rd_prev;
            n_slot_in = m_end[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
            mem_re    = rd_free && m_end_in;
            mem_raddr = m_end[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
         end
         ffsa_pkg::S_MRG_B: begin
            if (rd_free && n_slot_ff != m_slot_ff) begin
               // absorb the following free segment
               if (n_slot_ff == last_ff) begin
                  last_in = m_slot_ff;
               end
               mem_we       = 1'b1;
               mem_waddr    = m_slot_ff;
               wr_free      = 1'b1;
               wr_len       = LW'(merged_len);
               wr_prev      = m_prev_ff;
               fix_slot_in  = merged_end[SW+ffsa_pkg::GRAN_SHIFT-1:ffsa_pkg::GRAN_SHIFT];
               fix_prev_in  = m_slot_ff;
               fix_merge_in = 1'b1;
            end
         end
         ffsa_pkg::S_FIX_RD: begin
            mem_re    = 1'b1;
            mem_raddr = fix_slot_ff;
         end
         ffsa_pkg::S_FIX_WR: begin
            // relink the back pointer of the following segment
            mem_we    = 1'b1;
            mem_waddr = fix_slot_ff;
            wr_free   = rd_free;
            wr_len    = rd_len;
            wr_prev   = fix_prev_ff;
         end
         ffsa_pkg::S_RET: begin
            if (ret_ff == ffsa_pkg::RET_WALK) begin
               off_in = '0;
            end else if (ret_ff == ffsa_pkg::RET_BACK) begin
               m_slot_in = cur_prev_ff;
               ret_in    = ffsa_pkg::RET_DONE;
            end
         end
         ffsa_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsa_pkg::S_IDLE;
         ret_ff       <= ffsa_pkg::RET_DONE;
         arena_end_ff <= EW'(RESET_END);
         last_ff      <= '0;
         base_ff      <= '0;
         pages_ff     <= 5'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         arena_end_ff <= arena_end_in;
         last_ff      <= last_in;
         base_ff      <= base_in;
         pages_ff     <= pages_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      size_ff       <= size_in;
      target_ff     <= target_in;
      rel_ff        <= rel_in;
      cur_slot_ff   <= cur_slot_in;
      cur_prev_ff   <= cur_prev_in;
      split_ns_ff   <= split_ns_in;
      m_slot_ff     <= m_slot_in;
      m_len_ff      <= m_len_in;
      m_prev_ff     <= m_prev_in;
      n_slot_ff     <= n_slot_in;
      fix_slot_ff   <= fix_slot_in;
      fix_prev_ff   <= fix_prev_in;
      fix_go_ff     <= fix_go_in;
      fix_merge_ff  <= fix_merge_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   // register read back
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == ffsa_pkg::REG_INITIAL_PAGES) ?
                       {59'd0, pages_ff} : {16'd0, base_ff};

   // header ram is never read and written at one slot in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && mem_waddr == mem_raddr))
      else $error("header ram read and write collide");

   // a fit check always follows its own ram read
   a_walk_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffsa_pkg::S_WALK_CHK |-> $past(state_ff) == ffsa_pkg::S_WALK_RD)
      else $error("fit check without header read");

   // arena never grows past its bound
   a_arena_bound: assert property (@(posedge clock) disable iff (reset)
      32'(arena_end_ff) <= ARENA_BYTES)
      else $error("arena end past limit");

   // failed or zero-size requests return a null address
   a_null_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ffsa_pkg::ST_OK) |-> rsp_addr_ff == '0)
      else $error("error response with nonzero address");

endmodule

>>> rtl/ffsa_hdr_ram.sv
module ffsa_hdr_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 29
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> tb/allocator_checker.sv
module allocator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARENA   = 65536;
   localparam int HDR     = 32;
   localparam int GRAN    = ffsa_pkg::GRAN_BYTES;
   localparam int PAGE    = ffsa_pkg::PAGE_BYTES;
   localparam int NSLOTS  = ARENA / GRAN;

   typedef struct packed {
      logic [47:0] block_address;
      logic [1:0]  status;
   } alloc_result_type;

   int               seg_len  [NSLOTS];
   bit               seg_free [NSLOTS];
   int               seg_prev [NSLOTS];
   int               arena_end;
   int               last_seg;
   logic [47:0]      base_addr;
   logic [4:0]       init_pages;
   alloc_result_type expected_results[$];

   function automatic int slot(int off);
      return (off / GRAN) % NSLOTS;
   endfunction

   function automatic int seg_end(int s);
      return s * GRAN + HDR + seg_len[s];
   endfunction

   function automatic bit next_seg(int s, output int n);
      int off;
      off = seg_end(s);
      n = 0;
      if (off >= arena_end) return 0;
      n = slot(off);
      return 1;
   endfunction

   task automatic merge_next(int s);
      int n, nn;
      if (!seg_free[s]) return;
      if (!next_seg(s, n)) return;
      if (!seg_free[n] || n == s) return;
      if (n == last_seg) last_seg = s;
      seg_len[s] = seg_len[s] + seg_len[n] + HDR;
      if (next_seg(s, nn)) seg_prev[nn] = s;
   endtask

   task automatic merge_back(int s);
      if (s == 0) return;
      merge_next(seg_prev[s] % NSLOTS);
   endtask

   task automatic format_arena();
      int p;
      p = init_pages;
      if (p == 0) p = 1;
      if (p > ARENA / PAGE) p = ARENA / PAGE;
      arena_end   = p * PAGE;
      seg_len[0]  = arena_end - HDR;
      seg_free[0] = 1;
      seg_prev[0] = 0;
      last_seg    = 0;
   endtask

   // first-fit walk, growing the arena by pages when nothing fits
   task automatic allocate(int req, output alloc_result_type r);
      int size, off, s, len, ns, nn, grow;
      size = (req + GRAN - 1) / GRAN * GRAN;
      r = '0;
      if (size == 0) begin
         r.status = ffsa_pkg::ST_ZERO_SIZE;
         return;
      end
      forever begin
         off = 0;
         while (off < arena_end) begin
            s   = slot(off);
            len = seg_len[s];
            if (seg_free[s] && len >= size) begin
               if (len - size >= HDR + GRAN) begin
                  ns = slot(off + HDR + size);
                  seg_len[ns]  = len - size - HDR;
                  seg_free[ns] = 1;
                  seg_prev[ns] = s;
                  seg_len[s]   = size;
                  if (next_seg(ns, nn)) seg_prev[nn] = ns;
                  if (last_seg == s) last_seg = ns;
               end
               seg_free[s] = 0;
               r.block_address = base_addr + 48'(off + HDR);
               r.status = ffsa_pkg::ST_OK;
               return;
            end
            off = off + HDR + len;
         end
         grow = (size + PAGE - 1) / PAGE * PAGE;
         if (arena_end > ARENA || grow > ARENA - arena_end) begin
            r.status = ffsa_pkg::ST_OUT_OF_MEM;
            return;
         end
         ns = slot(arena_end);
         seg_free[ns] = 1;
         seg_prev[ns] = last_seg;
         seg_len[ns]  = grow - HDR;
         arena_end    = arena_end + grow;
         last_seg     = ns;
         merge_back(ns);
      end
   endtask

   task automatic release_block(logic [47:0] a);
      logic [47:0] rel;
      int off, target, s;
      rel = a - base_addr;
      off = 0;
      if (rel < HDR || rel - HDR >= arena_end) return;
      target = int'(rel - HDR);
      while (off < arena_end && off < target) off = seg_end(slot(off));
      if (off != target || off >= arena_end) return;
      s = slot(off);
      if (seg_free[s]) return;
      seg_free[s] = 1;
      merge_next(s);
      merge_back(s);
   endtask

   task automatic predict_request(logic [1:0] op, logic [71:0] data);
      alloc_result_type r;
      r = '0;
      case (op)
         ffsa_pkg::OP_ALLOC:  allocate(int'(data[16:0]), r);
         ffsa_pkg::OP_FREE:   release_block(data[64:17]);
         ffsa_pkg::OP_FORMAT: format_arena();
         default:   ;
      endcase
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         expected_results.delete();
         base_addr  = '0;
         init_pages = 5'd16;
         arena_end  = ARENA;
         last_seg   = 0;
         failures  <= 0;
         pending   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected word addr=%h status=%0d", $time, rsp_tdata,
                        rsp_tuser);
               failures <= failures + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.block_address !== rsp_tdata || want.status !== rsp_tuser) begin
                  $display("%0t: mismatch expected addr=%h status=%0d %s addr=%h status=%0d",
                           $time, want.block_address, want.status, "actual",
                           rsp_tdata, rsp_tuser);
                  failures <= failures + 1;
               end
            end
         end
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == ffsa_pkg::REG_BASE_ADDRESS) base_addr = csr_pwdata[47:0];
            else init_pages = csr_pwdata[4:0];
         end
         pending <= expected_results.size();
      end
   end

endmodule

>>> tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam logic [1:0] OP_UNUSED = 2'd3;  // op code with no operation

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = ffsa_pkg::OP_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int          failures;
   int          pending;
   bit          quiet = 1'b0;   // no idling on either side while set
   int          idle_count = 0;
   logic [47:0] live_blocks[$]; // payload addresses handed out, candidates for free

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   first_fit_segment_allocator i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   allocator_checker i_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .failures, .pending
   );

   // receiver drops ready at random with a chance of about 6 in a hundred
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet || ($urandom_range(99) >= 6);
   end

   // remember handed-out blocks so frees mostly hit real segments
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tuser == ffsa_pkg::ST_OK &&
          rsp_tdata != 0)
         live_blocks.push_back(rsp_tdata);
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_count <= 0;
      else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else idle_count <= idle_count + 1;
   end

   task automatic send_word(logic [1:0] op, logic [16:0] size, logic [47:0] addr);
      // the block is busy the cycle after it takes a word, so wait for a clock edge first
      @(posedge clock);
      // sender gap before the word
      if (!quiet && $urandom_range(99) < 6) repeat ($urandom_range(1, 4)) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, addr, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending != 0 || req_tvalid) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // registers are written only once the block is drained
   task automatic configure(logic [47:0] base, logic [4:0] pages);
      wait_drained();
      csr_write(4'h0, {16'd0, base});
      csr_write(4'h8, {59'd0, pages});
      live_blocks.delete();
      send_word(ffsa_pkg::OP_FORMAT, '0, '0);
   endtask

   function automatic logic [16:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 3) return '0;
      if (r < 70) return 17'($urandom_range(1, 256));
      if (r < 90) return 17'($urandom_range(257, 4096));
      if (r < 97) return 17'($urandom_range(4097, 65536));
      return 17'($urandom);
   endfunction

   task automatic random_word();
      int          r, k;
      logic [47:0] a;
      r = $urandom_range(99);
      if (r < 52) begin
         send_word(ffsa_pkg::OP_ALLOC, pick_size(), 48'($urandom) ^ {$urandom, 16'd0});
      end else if (r < 90) begin
         a = {16'($urandom), 32'($urandom)};
         if (live_blocks.size() != 0 && $urandom_range(99) < 85) begin
            k = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[k];
            // keep some entries to provoke double frees
            if ($urandom_range(99) < 85) live_blocks.delete(k);
            if ($urandom_range(99) < 5) a = a + 48'd16;  // inside a payload, not a start
         end
         send_word(ffsa_pkg::OP_FREE, 17'($urandom), a);
      end else if (r < 94) begin
         live_blocks.delete();
         send_word(ffsa_pkg::OP_FORMAT, 17'($urandom), {16'($urandom), 32'($urandom)});
      end else if (r < 96) send_word(OP_UNUSED, 17'($urandom), {16'($urandom), 32'($urandom)});
      else send_word(ffsa_pkg::OP_ALLOC, pick_size(), '0);
   endtask

   initial begin
      logic [47:0] a;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small arena so growth and the full-arena case show up quickly
      configure(48'h0000_0000_1000, 5'd1);
      send_word(ffsa_pkg::OP_ALLOC, 17'd0, '0);          // zero size
      send_word(ffsa_pkg::OP_ALLOC, 17'd1, '0);          // rounds up to one granule
      send_word(ffsa_pkg::OP_ALLOC, 17'd16, '0);
      send_word(ffsa_pkg::OP_ALLOC, 17'd17, '0);
      send_word(ffsa_pkg::OP_ALLOC, 17'd4000, '0);       // forces growth with backward merge
      send_word(ffsa_pkg::OP_ALLOC, 17'd65536, '0);      // larger than the arena
      send_word(ffsa_pkg::OP_ALLOC, 17'h1FFFF, '0);
      wait_drained();
      a = live_blocks[1];
      send_word(ffsa_pkg::OP_FREE, '0, a);
      send_word(ffsa_pkg::OP_FREE, '0, a);               // double free
      send_word(ffsa_pkg::OP_FREE, '0, live_blocks[0]);  // merges with free neighbor
      send_word(ffsa_pkg::OP_FREE, '0, 48'd5);           // unknown address
      send_word(ffsa_pkg::OP_FREE, '0, 48'hFFFF_FFFF_FFFF);
      send_word(OP_UNUSED, 17'h1FFFF, 48'hFFFF_FFFF_FFFF);
      send_word(ffsa_pkg::OP_ALLOC, 17'd60000, '0);      // needs more pages than remain: out of memory
      send_word(ffsa_pkg::OP_ALLOC, 17'd8192, '0);       // fits after growth with backward merge
      send_word(ffsa_pkg::OP_FORMAT, '0, '0);

      configure(48'hFFFF_FFFF_FFFF, 5'd0);     // page count zero, address wrap
      repeat (100) random_word();
      configure({16'($urandom), 32'($urandom)}, 5'd31);  // clamped page count
      quiet = 1'b1;
      repeat (120) random_word();
      quiet = 1'b0;
      configure({16'($urandom), 32'($urandom)}, 5'd16);
      repeat (100) random_word();
      configure(48'd0, 5'($urandom_range(1, 16)));
      repeat (100) random_word();
      configure({16'($urandom), 32'($urandom)}, 5'd2);
      repeat (80) random_word();

      wait_drained();
      repeat (20) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
